### sv/erfa_pkg.sv
// ----------------------------------------------------------------------------
// erfa_pkg
// Shared widths and fixed-point constants of the erf approximation datapath.
// ----------------------------------------------------------------------------
package erfa_pkg;

   localparam int IN_WIDTH_DEF  = 16;
   localparam int OUT_WIDTH_DEF = 16;

   localparam int ALPHA_W = 14;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 14'd9634;   // 0.147 in Q0.16

   localparam int AX_W     = 32;   // |x| in Q.28
   localparam int X2_W     = 39;   // x^2 in Q.32
   localparam int Z_W      = 36;   // a*x^2 in Q.32
   localparam int DEN_W    = 37;   // 1 + a*x^2 in Q.32
   localparam int QUO_W    = 24;   // (4/pi - 1)/den in Q.24
   localparam int RAT_W    = 25;   // ratio in Q.24
   localparam int E_W      = 40;   // exponent argument in Q.32
   localparam int FRAC_W   = 32;
   localparam int P_W      = 33;   // series value, up to 1.0 in Q.32
   localparam int K_W      = 6;
   localparam int INVLN2_W = 27;
   localparam int HORNER_TERMS = 12;
   localparam int ROOT_W     = 32;
   localparam int SQRT_STEPS = 32;

   localparam logic [31:0]         C_Q32      = 32'd1173554909;  // 4/pi - 1
   localparam logic [INVLN2_W-1:0] INVLN2_Q26 = 27'd96817625;    // 1/ln2
   localparam logic [31:0]         LN2_Q32    = 32'd2977044472;  // ln2
   localparam logic [E_W-1:0]      EXP_LIMIT  = 40'd23 << 32;
   localparam logic [P_W-1:0]      ONE_Q32    = 33'h1_0000_0000;

endpackage

### sv/erfa_exp.sv
// ----------------------------------------------------------------------------
// erfa_exp
// Pipelined exp(-e): range reduction to 2^-k * exp(-u), then a 12-term
// Horner series at three stages per term. One argument per cycle while en is high.
// ----------------------------------------------------------------------------
module erfa_exp
   import erfa_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  logic           in_sign,
   input  logic [E_W-1:0] in_e,
   output logic           out_valid,
   output logic           out_sign,
   output logic [P_W-1:0] out_expv
);

   localparam int HS   = 3 * HORNER_TERMS;
   localparam int PH_W = E_W - FRAC_W + INVLN2_W;
   localparam int PL_W = FRAC_W + INVLN2_W;
   localparam int TS_W = PH_W + FRAC_W + 1;

   // input register
   logic           v0_ff, s0_ff;
   logic [E_W-1:0] e0_ff;
   // split product e * (1/ln2)
   logic            v1_ff, s1_ff, z1_ff;
   logic [PH_W-1:0] ph1_ff;
   logic [PL_W-1:0] pl1_ff;
   // integer and fraction of e/ln2
   logic              v2_ff, s2_ff, z2_ff;
   logic [FRAC_W-1:0] f2_ff;
   logic [K_W-1:0]    k2_ff;
   logic [TS_W-1:0]   tsum;
   logic [2*FRAC_W-1:0] uprod;
   // series sidecars
   logic              hv_ff [0:HS];
   logic              hs_ff [0:HS];
   logic              hz_ff [0:HS];
   logic [K_W-1:0]    hk_ff [0:HS];
   logic [FRAC_W-1:0] hu_ff [0:HS-3];
   // series terms
   logic [FRAC_W-1:0] qa_ff [0:HORNER_TERMS-1];
   logic [FRAC_W-1:0] qb_ff [0:HORNER_TERMS-1];
   logic [FRAC_W-1:0] qh_ff [0:HORNER_TERMS-1];
   logic [P_W-1:0]    hp_ff [0:HORNER_TERMS-1];
   // output
   logic           ov_ff, os_ff;
   logic [P_W-1:0] expv_ff;

   assign tsum  = {1'b0, ph1_ff, {FRAC_W{1'b0}}} + TS_W'(pl1_ff);
   assign uprod = f2_ff * LN2_Q32;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         for (int i = 0; i <= HS; i++) hv_ff[i] <= 1'b0;
         ov_ff <= 1'b0;
      end else if (en) begin
         v0_ff    <= in_valid;
         v1_ff    <= v0_ff;
         v2_ff    <= v1_ff;
         hv_ff[0] <= v2_ff;
         for (int i = 1; i <= HS; i++) hv_ff[i] <= hv_ff[i-1];
         ov_ff    <= hv_ff[HS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_ff  <= in_sign;
         e0_ff  <= in_e;
         s1_ff  <= s0_ff;
         z1_ff  <= (e0_ff >= EXP_LIMIT);
         ph1_ff <= e0_ff[E_W-1:FRAC_W] * INVLN2_Q26;
         pl1_ff <= e0_ff[FRAC_W-1:0] * INVLN2_Q26;
         s2_ff  <= s1_ff;
         z2_ff  <= z1_ff;
         f2_ff  <= tsum[26 +: FRAC_W];
         k2_ff  <= tsum[26 + FRAC_W +: K_W];
         hs_ff[0] <= s2_ff;
         hz_ff[0] <= z2_ff;
         hk_ff[0] <= k2_ff;
         hu_ff[0] <= uprod[FRAC_W +: FRAC_W];
         for (int i = 1; i <= HS; i++) begin
            hs_ff[i] <= hs_ff[i-1];
            hz_ff[i] <= hz_ff[i-1];
            hk_ff[i] <= hk_ff[i-1];
         end
         for (int i = 1; i <= HS - 3; i++) hu_ff[i] <= hu_ff[i-1];
         os_ff   <= hs_ff[HS];
         expv_ff <= hz_ff[HS] ? '0 : (hp_ff[HORNER_TERMS-1] >> hk_ff[HS]);
      end
   end

   // p = 1 - (u*p)/n for n = 12 down to 1: multiply, divide by n, subtract
   for (genvar t = 0; t < HORNER_TERMS; t++) begin : g_term
      localparam int N = HORNER_TERMS - t;
      logic [P_W-1:0]        pin;
      logic [FRAC_W+P_W-1:0] prod;
      logic [FRAC_W-1:0]     back, rem, quot;

      if (t == 0) begin : g_first
         assign pin = ONE_Q32;
      end else begin : g_next
         assign pin = hp_ff[t-1];
      end

      assign prod = hu_ff[3*t] * pin;
      assign back = FRAC_W'(qh_ff[t] * FRAC_W'(N));
      assign rem  = qb_ff[t] - back;
      assign quot = (rem >= FRAC_W'(N)) ? qh_ff[t] + FRAC_W'(1) : qh_ff[t];

      if (N == 1) begin : g_unit
         always_ff @(posedge clock) begin
            if (en) begin
               qh_ff[t] <= qa_ff[t];
            end
         end
      end else begin : g_recip
         localparam logic [63:0] RECIP = (64'd1 << 32) / N;
         logic [2*FRAC_W-1:0] est;
         assign est = qa_ff[t] * RECIP[FRAC_W-1:0];
         always_ff @(posedge clock) begin
            if (en) begin
               qh_ff[t] <= est[FRAC_W +: FRAC_W];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            qa_ff[t] <= prod[FRAC_W +: FRAC_W];
            qb_ff[t] <= qa_ff[t];
            hp_ff[t] <= ONE_Q32 - {1'b0, quot};
         end
      end
   end

   assign out_valid = ov_ff;
   assign out_sign  = os_ff;
   assign out_expv  = expv_ff;

endmodule

### sv/erfa_sqrt.sv
// ----------------------------------------------------------------------------
// erfa_sqrt
// Pipelined integer square root of y * 2^30, one result bit per stage.
// ----------------------------------------------------------------------------
module erfa_sqrt
   import erfa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic              in_sign,
   input  logic [P_W-1:0]    in_y,
   output logic              out_valid,
   output logic              out_sign,
   output logic [ROOT_W-1:0] out_root
);

   localparam int V_W    = 2 * SQRT_STEPS;
   localparam int REM_W  = ROOT_W + 2;
   localparam int RS_W   = REM_W + 2;
   localparam int PRE_SH = 2 * (ROOT_W - 1) - FRAC_W;

   logic              sv_ff   [0:SQRT_STEPS];
   logic              ss_ff   [0:SQRT_STEPS];
   logic [ROOT_W-1:0] root_ff [0:SQRT_STEPS];
   logic [V_W-1:0]    val_ff  [0:SQRT_STEPS-1];
   logic [REM_W-1:0]  rem_ff  [0:SQRT_STEPS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= SQRT_STEPS; i++) sv_ff[i] <= 1'b0;
      end else if (en) begin
         sv_ff[0] <= in_valid;
         for (int i = 1; i <= SQRT_STEPS; i++) sv_ff[i] <= sv_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ss_ff[0]   <= in_sign;
         val_ff[0]  <= V_W'(in_y) << PRE_SH;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         for (int i = 1; i <= SQRT_STEPS; i++) ss_ff[i] <= ss_ff[i-1];
      end
   end

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
      logic [RS_W-1:0] rs, trial;
      logic            fits;

      assign rs    = {rem_ff[j], val_ff[j][V_W-1 -: 2]};
      assign trial = RS_W'({root_ff[j], 2'b01});
      assign fits  = (rs >= trial);

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[j+1] <= {root_ff[j][ROOT_W-2:0], fits};
         end
      end

      if (j < SQRT_STEPS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j+1] <= fits ? REM_W'(rs - trial) : REM_W'(rs);
               val_ff[j+1] <= val_ff[j] << 2;
            end
         end
      end
   end

   assign out_valid = sv_ff[SQRT_STEPS];
   assign out_sign  = ss_ff[SQRT_STEPS];
   assign out_root  = root_ff[SQRT_STEPS];

endmodule

### sv/erf_approximation_unit.sv
// ----------------------------------------------------------------------------
// erf_approximation_unit
// Error function by Winitzki's approximation, fully pipelined fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one signed Q3.12 argument per transfer (valid high, stall
//   low). rsp_* returns erf(x) as signed Q1.15, saturated to +/-32767, one
//   result per argument and in argument order.
//   csr_* writes the coefficient a (Q0.16); csr_ready is always high. Write
//   it only while no argument is in flight.
// Timing:
//   One argument per cycle while req_stall is low. A result passes through,
//   in order: x^2 and 1 + a*x^2, the divider (one quotient bit per stage),
//   ratio * x^2, exp (a series over 12 terms), the square root (one root
//   bit per stage), then rounding and the output register.
// Reset:
//   Clears all valid bits, including rsp_valid; loads a = 0.147.
// Stall:
//   A valid output register holds while rsp_stall is high; one more result lands
//   in a skid register, after which req_stall rises and the pipeline freezes.
// ----------------------------------------------------------------------------
module erf_approximation_unit
   import erfa_pkg::*;
#(
   parameter int IN_WIDTH  = IN_WIDTH_DEF,
   parameter int OUT_WIDTH = OUT_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [IN_WIDTH-1:0]  req_arg_x,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [OUT_WIDTH-1:0] rsp_erf_value,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [ALPHA_W-1:0]          csr_alpha_coeff
);

   localparam int DIV_STEPS = QUO_W;
   localparam int NUM_W     = 32 + QUO_W;
   localparam int RND_SH    = ROOT_W - OUT_WIDTH;
   localparam logic [ROOT_W:0] OUT_MAX =
      (ROOT_W+1)'((64'd1 << (OUT_WIDTH - 1)) - 64'd1);

   logic [ALPHA_W-1:0] alpha_ff;
   logic               en;

   // stage 1: magnitude
   logic [IN_WIDTH-1:0] x_bits, mag;
   logic [AX_W-1:0]     ax, ax1_ff;
   logic                v1_ff, n1_ff;
   // stage 2: x^2
   logic [2*AX_W-1:0] sq;
   logic [X2_W-1:0]   x2_2_ff;
   logic              v2_ff, n2_ff;
   // stage 3: a*x^2
   logic [ALPHA_W+X2_W-1:0] zp;
   logic [Z_W-1:0]          z3_ff;
   logic [X2_W-1:0]         x2_3_ff;
   logic                    v3_ff, n3_ff;
   // stage 4 and divider
   logic [DEN_W-1:0] den;
   logic [NUM_W-1:0] num;
   logic [DEN_W-1:0] dden_ff [0:DIV_STEPS-1];
   logic [DEN_W-1:0] drem_ff [0:DIV_STEPS-1];
   logic [QUO_W-1:0] dlo_ff  [0:DIV_STEPS-1];
   logic [QUO_W-1:0] dquo_ff [0:DIV_STEPS];
   logic [X2_W-1:0]  dx2_ff  [0:DIV_STEPS];
   logic             dn_ff   [0:DIV_STEPS];
   logic             dv_ff   [0:DIV_STEPS];
   // stage 5: ratio * x^2
   logic [RAT_W-1:0]      rat;
   logic [RAT_W+X2_W-1:0] ep5_ff, er;
   logic                  v5_ff, n5_ff;
   logic [E_W-1:0]        e5;
   // exp and square root
   logic              xv, xn, qv, qn;
   logic [P_W-1:0]    expv, y;
   logic [ROOT_W-1:0] root;
   // final rounding
   logic [ROOT_W:0]            m_full, m_sat;
   logic [OUT_WIDTH-1:0]       m_out, fin_value;
   logic                       fin_valid_ff;
   logic [OUT_WIDTH-1:0]       fin_value_ff;
   logic                       handoff;
   // output register and skid
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                 skid_valid_ff, skid_valid_in;
   logic [OUT_WIDTH-1:0] skid_value_ff, skid_value_in;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RESET;
      end else if (csr_valid && csr_ready) begin
         alpha_ff <= csr_alpha_coeff;
      end
   end

   // the whole pipeline advances unless the skid register is occupied
   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   assign x_bits = req_arg_x;
   assign mag    = x_bits[IN_WIDTH-1] ? (~x_bits + IN_WIDTH'(1)) : x_bits;
   assign ax     = AX_W'(mag) << (AX_W - IN_WIDTH);

   assign sq  = ax1_ff * ax1_ff;
   assign zp  = alpha_ff * x2_2_ff;
   assign den = DEN_W'(z3_ff) + (DEN_W'(1) << 32);
   assign num = {C_Q32, {QUO_W{1'b0}}} + NUM_W'(den[DEN_W-1:1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         for (int i = 0; i <= DIV_STEPS; i++) dv_ff[i] <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff    <= req_valid;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         dv_ff[0] <= v3_ff;
         for (int i = 1; i <= DIV_STEPS; i++) dv_ff[i] <= dv_ff[i-1];
         v5_ff    <= dv_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n1_ff      <= x_bits[IN_WIDTH-1];
         ax1_ff     <= ax;
         n2_ff      <= n1_ff;
         x2_2_ff    <= X2_W'((sq + (64'd1 << 23)) >> 24);
         n3_ff      <= n2_ff;
         x2_3_ff    <= x2_2_ff;
         z3_ff      <= Z_W'((zp + (ALPHA_W+X2_W)'(1 << 15)) >> 16);
         dn_ff[0]   <= n3_ff;
         dx2_ff[0]  <= x2_3_ff;
         dden_ff[0] <= den;
         drem_ff[0] <= DEN_W'(num[NUM_W-1:QUO_W]);
         dlo_ff[0]  <= num[QUO_W-1:0];
         dquo_ff[0] <= '0;
         for (int i = 1; i <= DIV_STEPS; i++) begin
            dn_ff[i]  <= dn_ff[i-1];
            dx2_ff[i] <= dx2_ff[i-1];
         end
         n5_ff  <= dn_ff[DIV_STEPS];
         ep5_ff <= rat * dx2_ff[DIV_STEPS];
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      logic [DEN_W:0] rs;
      logic           fits;

      assign rs   = {drem_ff[i], dlo_ff[i][QUO_W-1-i]};
      assign fits = (rs >= {1'b0, dden_ff[i]});

      always_ff @(posedge clock) begin
         if (en) begin
            dquo_ff[i+1] <= {dquo_ff[i][QUO_W-2:0], fits};
         end
      end

      if (i < DIV_STEPS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               drem_ff[i+1] <= fits ? DEN_W'(rs - {1'b0, dden_ff[i]}) : DEN_W'(rs);
               dden_ff[i+1] <= dden_ff[i];
               dlo_ff[i+1]  <= dlo_ff[i];
            end
         end
      end
   end

   assign rat = {1'b0, dquo_ff[DIV_STEPS]} + (RAT_W'(1) << QUO_W);
   assign er  = ep5_ff + ((RAT_W+X2_W)'(1) << 23);
   assign e5  = er[24 +: E_W];

   erfa_exp u_exp (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v5_ff),
      .in_sign   (n5_ff),
      .in_e      (e5),
      .out_valid (xv),
      .out_sign  (xn),
      .out_expv  (expv)
   );

   assign y = ONE_Q32 - expv;

   erfa_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (xv),
      .in_sign   (xn),
      .in_y      (y),
      .out_valid (qv),
      .out_sign  (qn),
      .out_root  (root)
   );

   // round half up to the output precision, saturate, apply the sign
   if (RND_SH > 0) begin : g_round
      logic [ROOT_W:0] rr;
      assign rr     = {1'b0, root} + ((ROOT_W+1)'(1) << (RND_SH - 1));
      assign m_full = rr >> RND_SH;
   end else begin : g_exact
      assign m_full = {1'b0, root};
   end

   assign m_sat     = (m_full > OUT_MAX) ? OUT_MAX : m_full;
   assign m_out     = m_sat[OUT_WIDTH-1:0];
   assign fin_value = qn ? (~m_out + OUT_WIDTH'(1)) : m_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (en) begin
         fin_valid_ff <= qv;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fin_value_ff <= fin_value;
      end
   end

   assign handoff = en && fin_valid_ff;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      skid_valid_in = skid_valid_ff;
      skid_value_in = skid_value_ff;
      if (!rsp_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = skid_value_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = handoff;
            rsp_value_in = fin_value_ff;
         end
      end else if (handoff) begin
         // output held: park the arriving result
         skid_valid_in = 1'b1;
         skid_value_in = fin_value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      skid_value_ff <= skid_value_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_erf_value = rsp_value_ff;

   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register holds a result while the output is empty");

   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("skid register filled without a held output");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (fin_valid_ff && rsp_valid_ff && rsp_stall && !skid_valid_ff) |=> skid_valid_ff)
      else $error("result lost while the output was held");

   a_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_value_ff != {1'b1, {(OUT_WIDTH-1){1'b0}}}))
      else $error("result outside the saturated range");

endmodule
